[hw/rtl/rc_pulse_capture_filter_top_macros.svh]
// ----------------------------------------------------------------------------
// RC pulse capture filter assertion macros
// Shared concurrent assertion forms for the capture filter modules.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_CAPTURE_FILTER_TOP_MACROS_SVH
`define RC_PULSE_CAPTURE_FILTER_TOP_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define RPCF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error(msg);

// Check that cons holds in the same cycle as ante.
`define RPCF_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rpcf_pkg.sv]
// ----------------------------------------------------------------------------
// RC pulse capture filter package
// Widths, codes, reset values, channel remap and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcf_pkg;

	localparam int NUM_CH     = 8;
	localparam int CH_W       = 3;
	localparam int TS_W       = 16;
	localparam int LVL_W      = 8;
	localparam int WID_W      = 12;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_DATA_W  = TS_W + LVL_W;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_PAD_W  = OUT_DATA_W - CH_W - 2 * WID_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 1'd1;

	// Opcodes
	localparam logic OP_PIN     = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [CFG_W-1:0] MIN_WIDTH_RST = 16'd1600;
	localparam logic [CFG_W-1:0] MAX_WIDTH_RST = 16'd4400;
	localparam logic [WID_W-1:0] DEFAULT_WIDTH = 12'd1500;
	localparam logic [WID_W-1:0] WIDTH_MAX     = 12'd4095;

	localparam logic [WID_W:0] HYS_BAND   = 13'd3;
	localparam logic [WID_W:0] HYS_OFFSET = 13'd2;

	localparam int AVERAGE_DEPTH_DEF = 4;

	typedef logic [CH_W-1:0] ch_t;

	localparam ch_t LAST_CH = 3'd7;

	// Logical channel to physical pin remap
	function automatic ch_t chan_map(input ch_t c);
		ch_t p;
		unique case (c)
			3'd0:    p = 3'd1;
			3'd1:    p = 3'd2;
			3'd2:    p = 3'd0;
			default: p = c;
		endcase
		return p;
	endfunction

	// Controller to datapath commands
	typedef struct packed {
		logic pin_we;
		logic start;
		logic rd_en;
		logic upd;
		logic mul;
		logic div;
		logic emit;
		logic last;
		ch_t  ch;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[hw/rtl/rpcf_ctrl.sv]
// ----------------------------------------------------------------------------
// RC pulse capture filter controller
// Accepts requests and sequences the per-channel filter steps of a compute.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc_pulse_capture_filter_top_macros.svh"

module rpcf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tuser,    // opcode
	output logic               s_tready,
	input  wire rpcf_pkg::sts_t sts,
	output rpcf_pkg::cmd_t     cmd
);
	import rpcf_pkg::*;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_RD   = 3'd1;
	localparam logic [ST_W-1:0] ST_UPD  = 3'd2;
	localparam logic [ST_W-1:0] ST_MUL  = 3'd3;
	localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
	localparam logic [ST_W-1:0] ST_HYS  = 3'd5;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_d;
	ch_t             ch_q;
	logic            accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Decode state into commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.ch   = ch_q;
		cmd.last = (ch_q == LAST_CH);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_COMPUTE) begin
						cmd.start = 1'b1;
						state_d   = ST_RD;
					end else begin
						cmd.pin_we = 1'b1;
					end
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_HYS;
			end
			ST_HYS: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = cmd.last ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				ch_q <= ch_q + 3'd1;
			end
		end
	end

	`RPCF_ASSERT_NEXT(a_start_reads, clk, arst_n, cmd.start, state_q == ST_RD, "compute did not start")
	`RPCF_ASSERT_NEXT(a_last_idle, clk, arst_n, cmd.emit && cmd.last, (state_q == ST_IDLE) && (ch_q == '0), "last result did not end compute")
	`RPCF_ASSERT_NEXT(a_ch_hold, clk, arst_n, !cmd.emit, $stable(ch_q), "channel moved without a result")

endmodule

`default_nettype wire

[hw/rtl/rpcf_datapath.sv]
// ----------------------------------------------------------------------------
// RC pulse capture filter datapath
// Pulse capture lanes, history memory with running sums, reciprocal
// divider, hysteresis and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc_pulse_capture_filter_top_macros.svh"

module rpcf_datapath #(
	parameter int AVERAGE_DEPTH = rpcf_pkg::AVERAGE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [rpcf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rpcf_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic [rpcf_pkg::IN_DATA_W-1:0]   s_tdata,   // timestamp, pin_levels
	input  wire rpcf_pkg::cmd_t                   cmd,
	output rpcf_pkg::sts_t                        sts,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [rpcf_pkg::OUT_DATA_W-1:0]       m_tdata,   // channel, average, hysteresis
	output logic                                  m_tlast
);
	import rpcf_pkg::*;

	localparam int PTR_W  = $clog2(AVERAGE_DEPTH);
	localparam int HIST_N = NUM_CH * AVERAGE_DEPTH;
	localparam int ADDR_W = $clog2(HIST_N);
	localparam int SUM_W  = WID_W + PTR_W;
	localparam int RECIP_K = SUM_W;
	localparam logic [SUM_W-1:0] SUM_RST    = SUM_W'(AVERAGE_DEPTH * int'(DEFAULT_WIDTH));
	localparam logic [SUM_W-1:0] HALF_DEPTH = SUM_W'(AVERAGE_DEPTH / 2);
	localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(AVERAGE_DEPTH);
	localparam logic [SUM_W-1:0] RECIP_M    = SUM_W'((1 << RECIP_K) / AVERAGE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(AVERAGE_DEPTH - 1);

	logic [CFG_W-1:0] min_q;
	logic [CFG_W-1:0] max_q;

	logic [TS_W-1:0]  ts;
	logic [LVL_W-1:0] levels;
	logic [LVL_W-1:0] prev_q;
	logic [LVL_W-1:0] changed;
	logic [TS_W-1:0]  rise_q [NUM_CH];
	logic [WID_W-1:0] capw_q [NUM_CH];
	logic [TS_W-1:0]  diff   [NUM_CH];
	logic [WID_W-1:0] wsat   [NUM_CH];
	logic [NUM_CH-1:0] in_win;

	logic [PTR_W-1:0]  ptr_q;
	logic [ADDR_W-1:0] addr;
	logic [WID_W-1:0]  hist_mem [HIST_N];
	logic [HIST_N-1:0] hist_vld_q;
	logic [WID_W-1:0]  rd_data_q;
	logic              rd_vld_q;
	logic [WID_W-1:0]  old_w;
	logic [WID_W-1:0]  new_w;
	logic [SUM_W-1:0]  sum_q [NUM_CH];
	logic [SUM_W-1:0]  sum_new;

	logic [SUM_W-1:0]   x_s1;
	logic [SUM_W-1:0]   x_s2;
	logic [2*SUM_W-1:0] prod_s2;
	logic [SUM_W-1:0]   q0;
	logic [SUM_W-1:0]   rem;
	logic [SUM_W-1:0]   quo;
	logic [WID_W-1:0]   avg_s3;

	logic [WID_W-1:0] hys_q [NUM_CH];
	logic [WID_W:0]   a13;
	logic [WID_W:0]   h13;
	logic [WID_W:0]   h1;
	logic [WID_W:0]   h2;
	logic [WID_W-1:0] h_new;

	logic             out_vld_q;
	ch_t              out_ch_q;
	logic [WID_W-1:0] out_avg_q;
	logic [WID_W-1:0] out_h_q;
	logic             out_last_q;
	logic [WID_W:0]   out_avg_ext;
	logic [WID_W:0]   out_h_ext;

	assign ts      = s_tdata[TS_W-1:0];
	assign levels  = s_tdata[IN_DATA_W-1:TS_W];
	assign changed = levels ^ prev_q;

	// Write limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_WIDTH_RST;
			max_q <= MAX_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_WIDTH: min_q <= cfg_data;
				REG_MAX_WIDTH: max_q <= cfg_data;
			endcase
		end
	end

	// Measure high time per pin lane
	always_comb begin
		for (int n = 0; n < NUM_CH; n++) begin
			diff[n]   = ts - rise_q[n];
			in_win[n] = (diff[n] > min_q) && (diff[n] < max_q);
			wsat[n]   = (diff[n][TS_W-1:1] > (TS_W-1)'(WIDTH_MAX)) ?
				WIDTH_MAX : diff[n][WID_W:1];
		end
	end

	// Record rises and capture accepted widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int n = 0; n < NUM_CH; n++) begin
				rise_q[n] <= '0;
				capw_q[n] <= DEFAULT_WIDTH;
			end
		end else if (cmd.pin_we) begin
			prev_q <= levels;
			for (int n = 0; n < NUM_CH; n++) begin
				if (changed[n]) begin
					if (levels[n]) begin
						rise_q[n] <= ts;
					end else if (in_win[n]) begin
						capw_q[n] <= wsat[n];
					end
				end
			end
		end
	end

	// Advance history pointer at compute start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.start) begin
			ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
		end
	end

	assign addr  = ADDR_W'(int'(cmd.ch) * AVERAGE_DEPTH + int'(ptr_q));
	assign new_w = capw_q[chan_map(cmd.ch)];
	assign old_w = rd_vld_q ? rd_data_q : DEFAULT_WIDTH;

	// History memory: read oldest entry, then overwrite it
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= hist_mem[addr];
		end
		if (cmd.upd) begin
			hist_mem[addr] <= new_w;
		end
	end

	// Track written history entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_vld_q <= hist_vld_q[addr];
			end
			if (cmd.upd) begin
				hist_vld_q[addr] <= 1'b1;
			end
		end
	end

	assign sum_new = sum_q[cmd.ch] - SUM_W'(old_w) + SUM_W'(new_w);

	// Update running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				sum_q[c] <= SUM_RST;
			end
		end else if (cmd.upd) begin
			sum_q[cmd.ch] <= sum_new;
		end
	end

	// Divide by depth: reciprocal estimate, then one correction step
	assign q0  = prod_s2[2*SUM_W-1:RECIP_K];
	assign rem = x_s2 - q0 * DEPTH_S;
	assign quo = (rem >= DEPTH_S) ? q0 + SUM_W'(1) : q0;

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			x_s1 <= sum_new + HALF_DEPTH;
		end
		if (cmd.mul) begin
			prod_s2 <= {{SUM_W{1'b0}}, x_s1} * {{SUM_W{1'b0}}, RECIP_M};
			x_s2    <= x_s1;
		end
		if (cmd.div) begin
			avg_s3 <= quo[WID_W-1:0];
		end
	end

	// Apply hysteresis: pull down first, then pull up
	assign a13   = {1'b0, avg_s3};
	assign h13   = {1'b0, hys_q[cmd.ch]};
	assign h1    = (a13 + HYS_BAND < h13) ? a13 + HYS_OFFSET : h13;
	assign h2    = (a13 > h1 + HYS_BAND) ? a13 - HYS_OFFSET : h1;
	assign h_new = h2[WID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				hys_q[c] <= '0;
			end
		end else if (cmd.emit) begin
			hys_q[cmd.ch] <= h_new;
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_ch_q   <= cmd.ch;
			out_avg_q  <= avg_s3;
			out_h_q    <= h_new;
			out_last_q <= cmd.last;
		end
	end

	assign sts.out_free = !out_vld_q || m_tready;
	assign m_tvalid     = out_vld_q;
	assign m_tdata      = {{OUT_PAD_W{1'b0}}, out_h_q, out_avg_q, out_ch_q};
	assign m_tlast      = out_last_q;

	assign out_avg_ext = {1'b0, out_avg_q};
	assign out_h_ext   = {1'b0, out_h_q};

	`RPCF_ASSERT_SAME(a_emit_free, clk, arst_n, cmd.emit, sts.out_free, "result overwrote a pending result")
	`RPCF_ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, m_tvalid, "emitted result not presented")
	`RPCF_ASSERT_NEXT(a_hys_band, clk, arst_n, cmd.emit, (out_h_ext + HYS_BAND >= out_avg_ext) && (out_avg_ext + HYS_BAND >= out_h_ext), "hysteresis left its band")

endmodule

`default_nettype wire

[hw/rtl/rc_pulse_capture_filter_top.sv]
// ----------------------------------------------------------------------------
// RC pulse capture filter top level
// Eight-channel receiver pulse capture with averaging and hysteresis filter.
// A pin-change request (tuser 0) is applied in the cycle in which it is taken
// and updates the rise times and captured widths of all eight pins at once. A
// compute request (tuser 1) returns eight results, channels 0 to 7, the last
// marked by tlast; each channel steps through history memory read, running-sum
// update, reciprocal multiply, correction and hysteresis in turn, set by the
// single history memory port and the shared divide step, and a result waits
// for a free output. No request is taken during a compute; a pin change may be
// taken while the last result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_capture_filter_top #(
	parameter int AVERAGE_DEPTH = rpcf_pkg::AVERAGE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rpcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rpcf_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [rpcf_pkg::IN_DATA_W-1:0] s_tdata,   // timestamp[15:0], pin_levels[23:16]
	input  wire logic                           s_tuser,   // opcode
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [rpcf_pkg::OUT_DATA_W-1:0]     m_tdata,   // channel[2:0], average_width[14:3],
	                                                       // hysteresis_width[26:15], zero pad
	output logic                                m_tlast
);
	import rpcf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rpcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpcf_datapath #(
		.AVERAGE_DEPTH (AVERAGE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire
